FILE: sv/stfw_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the semaphore table.
// No dependencies.
package stfw_pkg;

	typedef enum logic [1:0] {
		ACT_OPEN  = 2'd0,
		ACT_WAIT  = 2'd1,
		ACT_POST  = 2'd2,
		ACT_CLOSE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK             = 3'd0,
		ST_UNKNOWN        = 3'd1,
		ST_LISTENERS_FULL = 3'd2,
		ST_TABLE_FULL     = 3'd3,
		ST_QUEUE_FULL     = 3'd4
	} status_t;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		status_t     status;
		logic        must_block;
		logic        wake_valid;
		logic [7:0]  wake_pid;
	} result_t;

endpackage

FILE: sv/stfw_keys.sv
`timescale 1ns / 1ps
// Key store: valid bits and 32-bit keys in flops, parallel lookup,
// lowest matching slot and lowest free slot. Uses no package.
module stfw_keys #(
	parameter int SLOTS = 16,
	parameter int SW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   key,
	output logic          hit,
	output logic [SW-1:0] hit_idx,
	output logic          free_ok,
	output logic [SW-1:0] free_idx,
	input  logic          set,
	input  logic          clr,
	input  logic [SW-1:0] wr_idx,
	input  logic [31:0]   wr_key
);

	logic [SLOTS-1:0] valid_q;
	logic [31:0]      key_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (set)
				valid_q[wr_idx] <= 1'b1;
			else if (clr)
				valid_q[wr_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (set)
			key_q[wr_idx] <= wr_key;
	end

	// lowest index wins: scan downward so the last assignment is the lowest
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == key) begin
				hit     = 1'b1;
				hit_idx = SW'(i);
			end
			if (!valid_q[i]) begin
				free_ok  = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

endmodule

FILE: sv/stfw_ram.sv
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module stfw_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: sv/semaphore_table_fifo_wait.sv
`timescale 1ns / 1ps
// Semaphore table with per-semaphore FIFO wait queues.
// A request is accepted while idle; the slot RAM read-modify-write follows in
// the update state, and a post that wakes a waiter adds a pid RAM read
// state. One request in flight at a time: a new request is accepted only once
// the last result has moved into the output register, where it may wait on out_ready.
// Async active-low reset clears the FSM, the output valid and the key valid
// bits; RAM contents are not cleared.
module semaphore_table_fifo_wait #(
	parameter int SLOTS       = 16,
	parameter int MAX_WAITERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [31:0] sem_id,
	input  logic [15:0] initial_count,
	input  logic [7:0]  requester_pid,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        must_block,
	output logic        wake_valid,
	output logic [7:0]  wake_pid
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(MAX_WAITERS + 1);
	localparam int HW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int PD = SLOTS * MAX_WAITERS;
	localparam int AW = (PD > 1) ? $clog2(PD) : 1;
	localparam int DW = 16 + LW + LW + HW;

	typedef enum logic [1:0] {S_IDLE, S_RMW, S_PID, S_OUT} state_t;

	state_t state_q;

	// request captured at accept
	stfw_pkg::action_t act_s1;
	logic [31:0]       key_s1;
	logic [15:0]       init_s1;
	logic [7:0]        pid_s1;
	logic              hit_s1;
	logic              free_s1;
	logic [SW-1:0]     idx_s1;

	stfw_pkg::result_t res_q;
	stfw_pkg::result_t out_q;
	stfw_pkg::result_t fin;
	logic              out_valid_q;

	// key lookup runs on the request ports while idle
	logic          hit, free_ok;
	logic [SW-1:0] hit_idx, free_idx;
	logic          key_set, key_clr;

	stfw_keys #(.SLOTS(SLOTS), .SW(SW)) u_keys (
		.clk(clk), .arst_n(arst_n), .key(sem_id),
		.hit(hit), .hit_idx(hit_idx), .free_ok(free_ok), .free_idx(free_idx),
		.set(key_set), .clr(key_clr), .wr_idx(idx_s1), .wr_key(key_s1)
	);

	wire accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	// slot RAM: {count, listeners, waiter total, waiter head}
	logic          slot_we;
	logic [DW-1:0] slot_wdata, slot_rdata;

	stfw_ram #(.DEPTH(SLOTS), .AW(SW), .DW(DW)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(idx_s1), .wdata(slot_wdata),
		.re(accept), .raddr(hit ? hit_idx : free_idx), .rdata(slot_rdata)
	);

	// pid ring RAM, slot-major
	logic          pid_we, pid_re;
	logic [AW-1:0] pid_waddr, pid_raddr;
	logic [7:0]    pid_rdata;

	stfw_ram #(.DEPTH(PD), .AW(AW), .DW(8)) u_pid_ram (
		.clk(clk), .we(pid_we), .waddr(pid_waddr), .wdata(pid_s1),
		.re(pid_re), .raddr(pid_raddr), .rdata(pid_rdata)
	);

	// read-modify-write of the slot entry
	logic [15:0]   cur_cnt, new_cnt;
	logic [LW-1:0] cur_lst, new_lst, cur_tot, new_tot;
	logic [HW-1:0] cur_head, new_head, tail_pos;
	logic [LW:0]   pos_sum;
	logic [LW:0]   head_inc;
	logic          create;
	logic          go_pid;
	stfw_pkg::result_t rmw_res;

	always_comb begin
		create = (act_s1 == stfw_pkg::ACT_OPEN) && !hit_s1 && free_s1;
		if (create) begin
			cur_cnt  = init_s1;
			cur_lst  = '0;
			cur_tot  = '0;
			cur_head = '0;
		end else begin
			{cur_cnt, cur_lst, cur_tot, cur_head} = slot_rdata;
		end
		new_cnt  = cur_cnt;
		new_lst  = cur_lst;
		new_tot  = cur_tot;
		new_head = cur_head;

		pos_sum = (LW+1)'(cur_head) + (LW+1)'(cur_tot);
		if (pos_sum >= (LW+1)'(MAX_WAITERS))
			pos_sum = pos_sum - (LW+1)'(MAX_WAITERS);
		tail_pos = HW'(pos_sum);
		head_inc = (LW+1)'(cur_head) + (LW+1)'(1);
		if (head_inc >= (LW+1)'(MAX_WAITERS))
			head_inc = '0;

		rmw_res = '{stfw_pkg::ST_OK, 1'b0, 1'b0, 8'd0};
		key_set = 1'b0;
		key_clr = 1'b0;
		pid_we  = 1'b0;
		pid_re  = 1'b0;
		go_pid  = 1'b0;

		if (act_s1 == stfw_pkg::ACT_OPEN) begin
			key_set = (state_q == S_RMW) && create;
			if (!hit_s1 && !free_s1)
				rmw_res.status = stfw_pkg::ST_TABLE_FULL;
			else if (cur_lst >= LW'(MAX_WAITERS))
				rmw_res.status = stfw_pkg::ST_LISTENERS_FULL;
			else
				new_lst = cur_lst + LW'(1);
		end else if (!hit_s1) begin
			rmw_res.status = stfw_pkg::ST_UNKNOWN;
		end else if (act_s1 == stfw_pkg::ACT_WAIT) begin
			if (cur_cnt != 16'd0) begin
				new_cnt = cur_cnt - 16'd1;
			end else if (cur_tot >= LW'(MAX_WAITERS)) begin
				rmw_res.status = stfw_pkg::ST_QUEUE_FULL;
			end else begin
				pid_we  = (state_q == S_RMW);
				new_tot = cur_tot + LW'(1);
				rmw_res.must_block = 1'b1;
			end
		end else if (act_s1 == stfw_pkg::ACT_POST) begin
			if (cur_tot != '0) begin
				pid_re   = (state_q == S_RMW);
				go_pid   = 1'b1;
				new_head = HW'(head_inc);
				new_tot  = cur_tot - LW'(1);
			end else if (cur_cnt != stfw_pkg::COUNT_MAX) begin
				new_cnt = cur_cnt + 16'd1;
			end
		end else begin
			if (cur_lst != '0)
				new_lst = cur_lst - LW'(1);
			if (new_lst == '0) begin
				key_clr  = (state_q == S_RMW);
				new_tot  = '0;
				new_head = '0;
			end
		end
		slot_we    = (state_q == S_RMW) && (hit_s1 || create);
		slot_wdata = {new_cnt, new_lst, new_tot, new_head};
	end

	assign pid_waddr = AW'(idx_s1) * AW'(MAX_WAITERS) + AW'(tail_pos);
	assign pid_raddr = AW'(idx_s1) * AW'(MAX_WAITERS) + AW'(cur_head);

	// result ready this cycle, by state
	always_comb begin
		case (state_q)
			S_RMW:   fin = rmw_res;
			S_PID:   fin = '{stfw_pkg::ST_OK, 1'b0, 1'b1, pid_rdata};
			default: fin = res_q;
		endcase
	end

	wire out_free = !out_valid_q || out_ready;
	// a finished result moves into the output register this cycle
	wire out_load = (state_q != S_IDLE) && !(state_q == S_RMW && go_pid) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_s1  <= stfw_pkg::action_t'(action);
						key_s1  <= sem_id;
						init_s1 <= initial_count;
						pid_s1  <= requester_pid;
						hit_s1  <= hit;
						free_s1 <= free_ok;
						idx_s1  <= hit ? hit_idx : free_idx;
						state_q <= S_RMW;
					end
				end
				S_RMW, S_PID, S_OUT: begin
					if (state_q == S_RMW && go_pid) begin
						state_q <= S_PID;
					end else if (out_free) begin
						out_q   <= fin;
						state_q <= S_IDLE;
					end else begin
						res_q   <= fin;
						state_q <= S_OUT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign must_block = out_q.must_block;
	assign wake_valid = out_q.wake_valid;
	assign wake_pid   = out_q.wake_pid;

	// a pid read only follows the slot update of a post
	a_pid_after_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PID |-> $past(state_q) == S_RMW && act_s1 == stfw_pkg::ACT_POST)
		else $error("pid read stage entered out of order");

	// a result never both blocks and wakes
	a_block_wake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(must_block && wake_valid))
		else $error("result both blocks and wakes");

	// an accepted request always goes to the slot update next
	a_accept_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_RMW)
		else $error("accepted request skipped slot update");

	// pid RAM and key store never written outside the update cycle
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		(pid_we || key_set || key_clr) |-> state_q == S_RMW)
		else $error("state write outside update cycle");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for semaphore_table_fifo_wait.
// Depends on stfw_pkg and the semaphore_table_fifo_wait RTL.
module testbench;

	localparam int NSLOT = 16;
	localparam int NWAIT = 16;
	localparam int IDLE_LIMIT = 5000;

	// request record as seen at the input handshake
	typedef struct {
		stfw_pkg::action_t act;
		logic [31:0]       key;
		logic [15:0]       init;
		logic [7:0]        pid;
	} sem_req_t;

	// scoreboard: mirror of the semaphore table plus a queue of expected results
	class sem_scoreboard;
		bit                used[NSLOT];
		logic [31:0]       key[NSLOT];
		logic [15:0]       count[NSLOT];
		int                listeners[NSLOT];
		int                nwait[NSLOT];
		int                head[NSLOT];
		logic [7:0]        pids[NSLOT][NWAIT];
		stfw_pkg::result_t pending[$];
		int                mismatches;
		int                results_seen;
		int                wakes_seen;
		int                blocks_seen;

		function int lookup(logic [31:0] k);
			for (int i = 0; i < NSLOT; i++)
				if (used[i] && key[i] == k)
					return i;
			return -1;
		endfunction

		// apply one accepted request to the mirror and queue its result
		function void note_request(sem_req_t r);
			stfw_pkg::result_t res;
			int s;
			res = '{status: stfw_pkg::ST_OK, must_block: 1'b0, wake_valid: 1'b0,
				wake_pid: 8'd0};
			s = lookup(r.key);
			if (r.act == stfw_pkg::ACT_OPEN) begin
				if (s < 0) begin
					for (int i = 0; i < NSLOT; i++)
						if (!used[i]) begin
							s = i;
							break;
						end
					if (s >= 0) begin
						used[s] = 1;
						key[s] = r.key;
						count[s] = r.init;
						listeners[s] = 0;
						nwait[s] = 0;
						head[s] = 0;
					end
				end
				if (s < 0)
					res.status = stfw_pkg::ST_TABLE_FULL;
				else if (listeners[s] >= NWAIT)
					res.status = stfw_pkg::ST_LISTENERS_FULL;
				else
					listeners[s]++;
			end else if (s < 0) begin
				res.status = stfw_pkg::ST_UNKNOWN;
			end else if (r.act == stfw_pkg::ACT_WAIT) begin
				if (count[s] > 0)
					count[s]--;
				else if (nwait[s] >= NWAIT)
					res.status = stfw_pkg::ST_QUEUE_FULL;
				else begin
					pids[s][(head[s] + nwait[s]) % NWAIT] = r.pid;
					nwait[s]++;
					res.must_block = 1'b1;
				end
			end else if (r.act == stfw_pkg::ACT_POST) begin
				if (nwait[s] > 0) begin
					res.wake_valid = 1'b1;
					res.wake_pid = pids[s][head[s]];
					head[s] = (head[s] + 1) % NWAIT;
					nwait[s]--;
				end else if (count[s] != stfw_pkg::COUNT_MAX)
					count[s]++;
			end else begin
				if (listeners[s] > 0)
					listeners[s]--;
				// last listener gone: slot freed, queued pids dropped
				if (listeners[s] == 0) begin
					used[s] = 0;
					nwait[s] = 0;
					head[s] = 0;
				end
			end
			pending.push_back(res);
		endfunction

		function void check_result(stfw_pkg::result_t got);
			stfw_pkg::result_t want;
			results_seen++;
			if (got.wake_valid)
				wakes_seen++;
			if (got.must_block)
				blocks_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result mismatch: expected st=%0d blk=%0b wv=%0b wp=%0d, got st=%0d blk=%0b wv=%0b wp=%0d",
						want.status, want.must_block, want.wake_valid, want.wake_pid,
						got.status, got.must_block, got.wake_valid, got.wake_pid);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [31:0] sem_id;
	logic [15:0] initial_count;
	logic [7:0]  requester_pid;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic        must_block;
	logic        wake_valid;
	logic [7:0]  wake_pid;

	sem_scoreboard sb;
	bit  quiet_phase;   // no idling near the end of the run
	int  idle_cycles;
	int  requests_sent;
	logic [31:0] key_pool[8];

	semaphore_table_fifo_wait i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .sem_id(sem_id),
		.initial_count(initial_count), .requester_pid(requester_pid),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .must_block(must_block),
		.wake_valid(wake_valid), .wake_pid(wake_pid)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// drive one request; returns after the handshake with valid still high
	task automatic send_request(stfw_pkg::action_t act, logic [31:0] k,
			logic [15:0] init, logic [7:0] pid);
		sem_req_t r;
		int gap;
		// random burst of idle cycles ahead of the request
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		sem_id <= k;
		initial_count <= init;
		requester_pid <= pid;
		do
			@(posedge clk);
		while (!in_ready);
		r = '{act: act, key: k, init: init, pid: pid};
		sb.note_request(r);
		requests_sent++;
	endtask

	// mostly a key from a small pool so requests collide; sometimes anything
	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 9) == 0)
			return $urandom();
		return key_pool[$urandom_range(0, 7)];
	endfunction

	// result side: stall in bursts, check each accepted result
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet_phase && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				stall = $urandom_range(1, 16);
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result('{status: stfw_pkg::status_t'(status),
					must_block: must_block, wake_valid: wake_valid, wake_pid: wake_pid});
		end
	end

	// watchdog: cycles with no handshake on either channel
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("ERROR: timeout, no handshake for %0d cycles", IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int wait_cycles;
		sb = new();
		in_valid = 1'b0;
		action = stfw_pkg::ACT_OPEN;
		sem_id = '0;
		initial_count = '0;
		requester_pid = '0;
		quiet_phase = 1'b0;
		requests_sent = 0;
		arst_n = 1'b0;
		for (int i = 0; i < 8; i++)
			key_pool[i] = $urandom();
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unknown id on every non-open action
		send_request(stfw_pkg::ACT_WAIT, 32'h0, 16'h0, 8'h00);
		send_request(stfw_pkg::ACT_POST, 32'hFFFF_FFFF, 16'h0, 8'hFF);
		send_request(stfw_pkg::ACT_CLOSE, 32'h1234_5678, 16'h0, 8'h00);
		// count saturation at the top of the range
		send_request(stfw_pkg::ACT_OPEN, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
		send_request(stfw_pkg::ACT_POST, 32'hFFFF_FFFF, 16'h0, 8'h00);
		send_request(stfw_pkg::ACT_WAIT, 32'hFFFF_FFFF, 16'h0, 8'h00);
		// zero count: waits block, posts wake in order
		send_request(stfw_pkg::ACT_OPEN, 32'h0, 16'h0, 8'h00);
		send_request(stfw_pkg::ACT_WAIT, 32'h0, 16'h0, 8'hA5);
		send_request(stfw_pkg::ACT_WAIT, 32'h0, 16'h0, 8'h5A);
		send_request(stfw_pkg::ACT_POST, 32'h0, 16'h0, 8'h00);
		send_request(stfw_pkg::ACT_POST, 32'h0, 16'h0, 8'h00);
		send_request(stfw_pkg::ACT_POST, 32'h0, 16'h0, 8'h00);
		// close with waiters queued drops them
		send_request(stfw_pkg::ACT_WAIT, 32'h0, 16'h0, 8'h00);
		send_request(stfw_pkg::ACT_WAIT, 32'h0, 16'h0, 8'h00);
		send_request(stfw_pkg::ACT_WAIT, 32'h0, 16'h0, 8'hFF);
		send_request(stfw_pkg::ACT_CLOSE, 32'h0, 16'h0, 8'h00);
		send_request(stfw_pkg::ACT_POST, 32'h0, 16'h0, 8'h00);
		// wait queue full, listeners full, table full
		send_request(stfw_pkg::ACT_OPEN, 32'h0000_00AA, 16'h0, 8'h00);
		for (int i = 0; i < NWAIT + 1; i++)
			send_request(stfw_pkg::ACT_WAIT, 32'h0000_00AA, 16'h0, 8'(i));
		for (int i = 0; i < NWAIT; i++)
			send_request(stfw_pkg::ACT_OPEN, 32'h0000_00AA, 16'h0, 8'h00);
		for (int i = 0; i < NSLOT; i++)
			send_request(stfw_pkg::ACT_OPEN, 32'h1000 + i, 16'(i), 8'h00);
		// drain the table again so random traffic starts from empty
		for (int i = 0; i < NSLOT; i++)
			send_request(stfw_pkg::ACT_CLOSE, 32'h1000 + i, 16'h0, 8'h00);
		for (int i = 0; i < NWAIT + 1; i++)
			send_request(stfw_pkg::ACT_CLOSE, 32'h0000_00AA, 16'h0, 8'h00);
		send_request(stfw_pkg::ACT_CLOSE, 32'hFFFF_FFFF, 16'h0, 8'h00);

		// random: small key pool keeps semaphores alive and queues filling
		for (int n = 0; n < 350; n++) begin
			stfw_pkg::action_t act;
			logic [15:0] init;
			if (n >= 300)
				quiet_phase = 1'b1;
			case ($urandom_range(0, 9))
				0, 1:    act = stfw_pkg::ACT_OPEN;
				2, 3, 4: act = stfw_pkg::ACT_WAIT;
				5, 6, 7: act = stfw_pkg::ACT_POST;
				default: act = stfw_pkg::ACT_CLOSE;
			endcase
			// small counts mostly so waits reach zero and block
			case ($urandom_range(0, 5))
				0:       init = 16'($urandom());
				1:       init = 16'hFFFF;
				default: init = 16'($urandom_range(0, 3));
			endcase
			send_request(act, pick_key(), init, 8'($urandom()));
		end
		in_valid <= 1'b0;

		wait_cycles = 0;
		while (sb.pending.size() != 0 && wait_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);

		$display("Sent %0d requests, checked %0d results (%0d blocked waits, %0d wakes).",
			requests_sent, sb.results_seen, sb.blocks_seen, sb.wakes_seen);
		$display("Mismatches: %0d, results still outstanding: %0d.",
			sb.mismatches, sb.pending.size());
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
